// ===== design/smpq_pkg.sv =====
package smpq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4
  } status_e;

  typedef struct packed {
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [AW-1:0]          raddr;
  } mem_req_t;

endpackage

// ===== design/smpq_ram.sv =====
module smpq_ram #(
  parameter int AW = 4,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/smpq_ctrl.sv =====
module smpq_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           action_i,
  input  logic signed [31:0]                   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           status_o,
  output logic [3:0]                           position_o,
  output logic signed [31:0]                   top_value_o,
  output logic [4:0]                           entry_count_o,
  output logic                                 last_o,
  output smpq_pkg::mem_req_t                   mem_req_o,
  input  logic [smpq_pkg::VALUE_WIDTH-1:0]     rdata_i
);
  import smpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_PUSH_TOP,
    S_POP,
    S_SRCH,
    S_RESP
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic [CW-1:0]          count_q, count_d;
  logic [VALUE_WIDTH-1:0] top_q, top_d;
  logic                   zero0_q, zero0_d;
  logic [AW-1:0]          raddr_q, raddr_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_pos_q, pend_pos_d;
  status_e                resp_status_q, resp_status_d;
  logic [AW-1:0]          resp_pos_q, resp_pos_d;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [3:0]             out_pos_q, out_pos_d;
  logic [31:0]            out_top_q, out_top_d;
  logic [4:0]             out_count_q, out_count_d;
  logic                   out_last_q, out_last_d;

  mem_req_t               req;
  logic [VALUE_WIDTH-1:0] rd;
  logic                   slot_free;
  logic                   emit;
  status_e                emit_status;
  logic [AW-1:0]          emit_pos;
  logic                   emit_last;
  logic                   match;
  logic                   at_end;

  // entry 0 reads as zero until first written
  assign rd        = (raddr_q == '0 && zero0_q) ? '0 : rdata_i;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign match     = (rd == v_q);
  assign at_end    = (CW'(idx_q) == count_q - CW'(1));

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    v_d           = v_q;
    count_d       = count_q;
    top_d         = top_q;
    zero0_d       = zero0_q;
    raddr_d       = raddr_q;
    pend_d        = pend_q;
    pend_pos_d    = pend_pos_q;
    resp_status_d = resp_status_q;
    resp_pos_d    = resp_pos_q;
    req           = '0;
    emit          = 1'b0;
    emit_status   = ST_DONE;
    emit_pos      = '0;
    emit_last     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_d = VALUE_WIDTH'(value_i);
          unique case (action_e'(action_i))
            ACT_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                resp_status_d = ST_FULL;
                resp_pos_d    = '0;
                state_d       = S_RESP;
              end else begin
                idx_d     = AW'(count_q);
                req.re    = 1'b1;
                req.raddr = AW'(count_q - CW'(1));
                state_d   = S_PUSH;
              end
            end
            ACT_POP: begin
              if (count_q < CW'(2)) begin
                resp_status_d = ST_REFUSED;
                resp_pos_d    = '0;
                state_d       = S_RESP;
              end else begin
                idx_d     = '0;
                req.re    = 1'b1;
                req.raddr = AW'(1);
                state_d   = S_POP;
              end
            end
            ACT_SEARCH: begin
              idx_d     = '0;
              pend_d    = 1'b0;
              req.re    = 1'b1;
              req.raddr = '0;
              state_d   = S_SRCH;
            end
            default: begin
              resp_status_d = ST_DONE;
              resp_pos_d    = '0;
              state_d       = S_RESP;
            end
          endcase
        end
      end

      // rd holds entry idx_q-1
      S_PUSH: begin
        req.we    = 1'b1;
        req.waddr = idx_q;
        if ($signed(v_q) > $signed(rd)) begin
          req.wdata = rd;
          idx_d     = idx_q - AW'(1);
          if (idx_q == AW'(1)) begin
            state_d = S_PUSH_TOP;
          end else begin
            req.re    = 1'b1;
            req.raddr = idx_q - AW'(2);
          end
        end else begin
          req.wdata     = v_q;
          count_d       = count_q + CW'(1);
          resp_status_d = ST_DONE;
          resp_pos_d    = '0;
          state_d       = S_RESP;
        end
      end

      S_PUSH_TOP: begin
        req.we        = 1'b1;
        req.waddr     = '0;
        req.wdata     = v_q;
        count_d       = count_q + CW'(1);
        resp_status_d = ST_DONE;
        resp_pos_d    = '0;
        state_d       = S_RESP;
      end

      // rd holds entry idx_q+1
      S_POP: begin
        req.we    = 1'b1;
        req.waddr = idx_q;
        req.wdata = rd;
        if (CW'(idx_q) + CW'(1) == count_q - CW'(1)) begin
          count_d       = count_q - CW'(1);
          resp_status_d = ST_DONE;
          resp_pos_d    = '0;
          state_d       = S_RESP;
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_q + AW'(2);
          idx_d     = idx_q + AW'(1);
        end
      end

      // one match is held back until we know whether it is the last
      S_SRCH: begin
        if (!(match && pend_q && !slot_free)) begin
          if (match && pend_q) begin
            emit        = 1'b1;
            emit_status = ST_FOUND;
            emit_pos    = pend_pos_q;
            emit_last   = 1'b0;
          end
          if (match) begin
            pend_d     = 1'b1;
            pend_pos_d = idx_q;
          end
          if (!match && pend_q) begin
            resp_status_d = ST_FOUND;
            resp_pos_d    = pend_pos_q;
            state_d       = S_RESP;
          end else if (at_end) begin
            resp_status_d = match ? ST_FOUND : ST_NOT_FOUND;
            resp_pos_d    = match ? idx_q : '0;
            state_d       = S_RESP;
          end else begin
            req.re    = 1'b1;
            req.raddr = idx_q + AW'(1);
            idx_d     = idx_q + AW'(1);
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = resp_status_q;
          emit_pos    = resp_pos_q;
          emit_last   = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (req.re) begin
      raddr_d = req.raddr;
    end
    if (req.we && req.waddr == '0) begin
      top_d   = req.wdata;
      zero0_d = 1'b0;
    end

    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_top_d    = out_top_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = emit_status;
      out_pos_d    = 4'(emit_pos);
      out_top_d    = 32'(top_q);
      out_count_d  = 5'(count_q);
      out_last_d   = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CW'(1);
      top_q       <= '0;
      zero0_q     <= 1'b1;
      pend_q      <= 1'b0;
      raddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      v_q           <= v_d;
      count_q       <= count_d;
      top_q         <= top_d;
      zero0_q       <= zero0_d;
      raddr_q       <= raddr_d;
      pend_q        <= pend_d;
      pend_pos_q    <= pend_pos_d;
      resp_status_q <= resp_status_d;
      resp_pos_q    <= resp_pos_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_pos_q     <= out_pos_d;
      out_top_q     <= out_top_d;
      out_count_q   <= out_count_d;
      out_last_q    <= out_last_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign mem_req_o     = req;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign top_value_o   = out_top_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

endmodule

// ===== design/sorted_max_priority_queue.sv =====
// Sorted max priority queue.
// Input channel (in_valid_i / in_stall_o) carries one item: action_i and value_i.
// Push inserts value_i in descending order, pop removes the largest entry,
// search reports every position holding value_i.
// Output channel (out_valid_o / out_stall_i) returns one result per push, pop
// or unused code, and one per match (or a single not-found result) for search;
// last_o marks the final result of an item. Every result carries the top value
// and the entry count after the operation.
// Entries live in a one-port-write, one-port-read RAM with a registered read;
// push and pop are read-shift-write sweeps over that RAM and search a read
// sweep, one entry per cycle (a stalled receiver can hold the search scan);
// full push, refused pop and unused codes make no sweep. in_stall_o is high
// while an item is in work, so an item is taken only once the previous item
// has handed its last result to the output register; a new item may be taken
// while the previous result still waits at the output.
// A stalled receiver holds the output register and, during search, the scan.
// Reset leaves one zero entry (count 1) and an empty output register; no
// clearing pass is needed.
module sorted_max_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [3:0]         position_o,
  output logic signed [31:0] top_value_o,
  output logic [4:0]         entry_count_o,
  output logic               last_o
);
  import smpq_pkg::*;

  mem_req_t               mem_req;
  logic [VALUE_WIDTH-1:0] rdata;

  smpq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .top_value_o   (top_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o),
    .mem_req_o     (mem_req),
    .rdata_i       (rdata)
  );

  smpq_ram #(
    .AW (AW),
    .DW (VALUE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== design/smpq_checker.sv =====
module smpq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic [3:0]         position_o,
  input logic signed [31:0] top_value_o,
  input logic [4:0]         entry_count_o,
  input logic               last_o
);
  import smpq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(position_o) && $stable(top_value_o) && $stable(entry_count_o) &&
      $stable(last_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o != 5'd0 && entry_count_o <= 5'(DEPTH))
    else $error("entry count out of range");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |-> position_o == 4'd0)
    else $error("position set on non-match result");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |-> last_o)
    else $error("single result not marked last");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == 5'(DEPTH))
    else $error("full drop while not full");

endmodule

bind sorted_max_priority_queue smpq_checker u_smpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .position_o    (position_o),
  .top_value_o   (top_value_o),
  .entry_count_o (entry_count_o),
  .last_o        (last_o)
);
